[rtl/core/value_noise_material_texel_defines.svh]
// Assertion macros used by the checker of the texel generator.
// No dependencies; take in with `include by bare file name.
`ifndef VALUE_NOISE_MATERIAL_TEXEL_DEFINES_SVH
`define VALUE_NOISE_MATERIAL_TEXEL_DEFINES_SVH

// Delayed implication; the delay is given by the argument n.
`define VNMT_ASSERT_DLY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

// Same-cycle implication.
`define VNMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/vnmt_pkg.sv]
// Shared types, constants and arithmetic helpers of the texel generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vnmt_pkg;

    localparam int TEX_WIDTH  = 512;
    localparam int TEX_HEIGHT = 512;

    localparam int LATENCY = 15;   // request to result, in cycles
    localparam int HW      = 18;   // signed Q1.16 noise width
    localparam int VW      = 20;   // signed width of the colour arithmetic
    localparam int FW      = 13;   // octave frequency width (Q16)

    typedef struct packed {
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
    } t_texel_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_texel_out;

    typedef logic [16:0] t_wtab [256];

    localparam longint unsigned PI_Q28  = 64'd843314857;
    localparam longint unsigned ONE_Q28 = 64'd268435456;
    localparam longint unsigned TAYLOR_DIV [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

    // Cosine blend weight (1-cos(pi*k/256))/2 in Q16, by Taylor series in Q28.
    function automatic t_wtab f_cos_table();
        t_wtab           tab;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          c;
        longint          w;
        int              k;
        int              n;
        for (k = 0; k < 256; k++) begin
            a    = (PI_Q28 * longint'(k)) >> 8;
            a2   = (a * a) >> 28;
            term = ONE_Q28;
            c    = longint'(ONE_Q28);
            for (n = 1; n <= 12; n++) begin
                term = ((term * a2) >> 28) / TAYLOR_DIV[n - 1];
                if ((n % 2) == 1) begin
                    c = c - longint'(term);
                end else begin
                    c = c + longint'(term);
                end
            end
            w = longint'(ONE_Q28) - c;
            if (w < 0) begin
                w = 0;
            end
            w = (w + 4096) >>> 13;
            if (w > 65536) begin
                w = 65536;
            end
            tab[k] = w[16:0];
        end
        return tab;
    endfunction

    localparam t_wtab COS_W = f_cos_table();

    // floor(a*b/65536)
    function automatic logic signed [VW-1:0] f_mul16(input logic signed [VW-1:0] a,
                                                      input logic signed [VW-1:0] b);
        logic signed [2*VW-1:0] p;
        p = a * b;
        return p[VW+15:16];
    endfunction

    // a + floor((b-a)*w/65536)
    function automatic logic signed [HW-1:0] f_blend(input logic signed [HW-1:0] a,
                                                      input logic signed [HW-1:0] b,
                                                      input logic [16:0] w);
        logic signed [HW:0]    d;
        logic signed [HW+18:0] p;
        logic signed [HW:0]    r;
        d = (HW+1)'(b) - (HW+1)'(a);
        p = d * $signed({1'b0, w});
        r = (HW+1)'(a) + p[HW+16:16];
        return r[HW-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/core/value_noise_material_texel.sv]
// Top level of the procedural material texel generator.
// Depends on vnmt_pkg and vnmt_octave.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//  Request channel: drive i_pixel and raise start; a request is taken at
//  every rising edge with start high and busy low. busy never rises, so a
//  new pixel may be presented in every cycle.
//  Result channel: o_texel is valid for the one cycle in which o_strobe is
//  high. The receiver cannot stall; results appear in request order.
//  Throughput is one texel per cycle, set by the fully pipelined octave
//  lanes (hash, smoothing and blend stages) and the colour stages after them.
//  Configuration: the material register is written through i_cfg_valid /
//  o_cfg_ready / i_cfg_data. The user must write it only while no request
//  is in flight; the block itself does not enforce this.
//  Reset (synchronous, active low) clears the material to light wood and
//  drops every request still in the pipeline.
module value_noise_material_texel (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire vnmt_pkg::t_texel_in    i_pixel,
    output logic                        o_strobe,
    output vnmt_pkg::t_texel_out        o_texel,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [3:0]             i_cfg_data
);
    import vnmt_pkg::*;

    localparam logic [3:0] MAT_DARK_WOOD    = 4'd1;
    localparam logic [3:0] MAT_WHITE_MARBLE = 4'd2;
    localparam logic [3:0] MAT_BLACK_MARBLE = 4'd3;
    localparam logic [3:0] MAT_SILVER       = 4'd5;

    localparam logic [1:0] GRP_WOOD   = 2'd0;
    localparam logic [1:0] GRP_MARBLE = 2'd1;
    localparam logic [1:0] GRP_METAL  = 2'd2;
    localparam logic [1:0] GRP_GEM    = 2'd3;

    // base colours by material code; unused codes take mid grey
    localparam logic signed [VW-1:0] BASE_R [16] = '{
        20'sd62259, 20'sd39322, 20'sd62259, 20'sd6554, 20'sd52429, 20'sd52429,
        20'sd0, 20'sd52429, 20'sd6554, 20'sd58982, 20'sd32768, 20'sd32768,
        20'sd32768, 20'sd32768, 20'sd32768, 20'sd32768};
    localparam logic signed [VW-1:0] BASE_G [16] = '{
        20'sd55706, 20'sd26214, 20'sd62259, 20'sd6554, 20'sd39322, 20'sd52429,
        20'sd52429, 20'sd6554, 20'sd6554, 20'sd58982, 20'sd32768, 20'sd32768,
        20'sd32768, 20'sd32768, 20'sd32768, 20'sd32768};
    localparam logic signed [VW-1:0] BASE_B [16] = '{
        20'sd42598, 20'sd13107, 20'sd58982, 20'sd9830, 20'sd13107, 20'sd58982,
        20'sd26214, 20'sd6554, 20'sd52429, 20'sd65536, 20'sd32768, 20'sd32768,
        20'sd32768, 20'sd32768, 20'sd32768, 20'sd32768};

    localparam int MX = (1 << 20) / TEX_WIDTH;
    localparam int MY = (1 << 20) / TEX_HEIGHT;

    logic                   accept;
    logic [3:0]             r_material;
    logic [1:0]             grp;
    logic [LATENCY-1:0]     r_valid;
    logic [31:0]            qx, qy, rx, ry;
    logic [8:0]             r_px, r_py;
    logic [FW-1:0]          freq [4];
    logic signed [VW-1:0]   kmul [4];
    logic signed [HW-1:0]   oct [4];
    logic signed [VW-1:0]   r_p [4];
    logic signed [VW-1:0]   r_a10, r_b10, r_a11, r_b11, r_c11, r_b12, r_y12;
    logic signed [VW-1:0]   n_a, n_b, n_c, src;
    logic signed [VW-1:0]   r_x [3];
    logic signed [VW-1:0]   r_col [3];
    logic signed [VW-1:0]   n_col [3];
    logic [16:0]            clip [3];
    logic [7:0]             chan [3];

    assign accept      = start && !busy;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_valid[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_material <= '0;
            r_valid    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_material <= i_cfg_data;
            end
            // advance the valid bits with the data
            r_valid <= {r_valid[LATENCY-2:0], accept};
        end
    end

    always_comb begin
        if (r_material <= MAT_DARK_WOOD) begin
            grp = GRP_WOOD;
        end else if (r_material <= MAT_BLACK_MARBLE) begin
            grp = GRP_MARBLE;
        end else if (r_material <= MAT_SILVER) begin
            grp = GRP_METAL;
        end else begin
            grp = GRP_GEM;
        end
    end

    // wrap coordinates to the texture: reciprocal estimate, one correction
    always_comb begin
        qx = (32'(i_pixel.pixel_x) * 32'(MX)) >> 20;
        qy = (32'(i_pixel.pixel_y) * 32'(MY)) >> 20;
        rx = 32'(i_pixel.pixel_x) - qx * 32'(TEX_WIDTH);
        ry = 32'(i_pixel.pixel_y) - qy * 32'(TEX_HEIGHT);
        if (rx >= 32'(TEX_WIDTH))  rx = rx - 32'(TEX_WIDTH);
        if (ry >= 32'(TEX_HEIGHT)) ry = ry - 32'(TEX_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        r_px <= rx[8:0];
        r_py <= ry[8:0];
    end

    // octave frequencies and weights per lane
    always_comb begin
        unique case (grp)
            GRP_WOOD: begin
                freq = '{13'd655, 13'd1311, 13'd0, 13'd0};
                kmul = '{20'sd13107, 20'sd9830, 20'sd0, 20'sd0};
            end
            GRP_MARBLE: begin
                freq = '{13'd328, 13'd655, 13'd1311, 13'd1966};
                kmul = '{20'sd32768, 20'sd19661, 20'sd13107, 20'sd6554};
            end
            GRP_METAL: begin
                freq = '{13'd3277, 13'd6554, 13'd0, 13'd0};
                kmul = '{20'sd13107, 20'sd19661, 20'sd0, 20'sd0};
            end
            default: begin
                freq = '{13'd1311, 13'd2621, 13'd5243, 13'd0};
                kmul = '{20'sd39322, 20'sd26214, 20'sd32768, 20'sd0};
            end
        endcase
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        vnmt_octave u_octave (
            .i_clk  (i_clk),
            .i_px   (r_px),
            .i_py   (r_py),
            .i_freq (freq[g]),
            .o_oct  (oct[g])
        );
    end

    // combine the octaves into the two material terms
    always_comb begin
        unique case (grp)
            GRP_WOOD: begin
                n_a = r_p[0] + 20'sd52429;
                n_b = r_p[1] + 20'sd55706;
            end
            GRP_MARBLE: begin
                n_a = r_p[0] + r_p[1] + r_p[2];
                n_b = r_p[3] + 20'sd58982;
            end
            GRP_METAL: begin
                n_a = r_p[0] + 20'sd52429;
                n_b = r_p[1] + 20'sd45875;
            end
            default: begin
                n_a = r_p[0] + r_p[1];
                n_b = r_p[2] + 20'sd32768;
            end
        endcase
    end

    always_comb begin
        unique case (grp)
            GRP_WOOD:   n_c = f_mul16(r_a10, r_b10);
            GRP_MARBLE: n_c = f_mul16(r_a10, 20'sd26214);
            GRP_METAL:  n_c = r_a10;
            default:    n_c = f_mul16(r_a10, 20'sd19661) + 20'sd45875;
        endcase
    end

    always_comb begin
        unique case (grp)
            GRP_MARBLE: src = r_b11;
            GRP_METAL:  src = r_a11;
            default:    src = r_c11;
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            unique case (grp)
                GRP_WOOD:   n_col[c] = r_x[c];
                GRP_MARBLE: n_col[c] = r_x[c] + r_y12;
                default:    n_col[c] = f_mul16(r_x[c], r_b12);
            endcase
            // saturate to [0,1] and scale to a byte
            if (r_col[c] < 0) begin
                clip[c] = '0;
            end else if (r_col[c] > 20'sd65536) begin
                clip[c] = 17'd65536;
            end else begin
                clip[c] = r_col[c][16:0];
            end
            chan[c] = 8'(((25'(clip[c]) << 8) - 25'(clip[c])) >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 4; g++) begin
            r_p[g] <= f_mul16(VW'(oct[g]), kmul[g]);
        end
        r_a10 <= n_a;
        r_b10 <= n_b;
        r_a11 <= r_a10;
        r_b11 <= r_b10;
        r_c11 <= n_c;
        r_x[0] <= f_mul16(BASE_R[r_material], src);
        r_x[1] <= f_mul16(BASE_G[r_material], src);
        r_x[2] <= f_mul16(BASE_B[r_material], src);
        r_y12  <= f_mul16(r_c11, (r_material == MAT_WHITE_MARBLE) ? 20'sd19661 : 20'sd6554);
        r_b12  <= r_b11;
        r_col  <= n_col;
        o_texel.red   <= chan[0];
        o_texel.green <= chan[1];
        o_texel.blue  <= chan[2];
    end

endmodule
`default_nettype wire

[rtl/core/vnmt_octave.sv]
// One octave of smoothed, cosine-blended value noise, eight register stages.
// Depends on vnmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vnmt_octave (
    input  wire logic                         i_clk,
    input  wire logic [8:0]                   i_px,
    input  wire logic [8:0]                   i_py,
    input  wire logic [vnmt_pkg::FW-1:0]      i_freq,
    output logic signed [vnmt_pkg::HW-1:0]    o_oct
);
    import vnmt_pkg::*;

    logic [21:0] r_sx, r_sy;
    logic [5:0]  ix, iy;
    logic [31:0] base;
    logic [31:0] n_key [4][4];
    logic [31:0] n_t [4][4];
    logic [31:0] r_n2 [4][4];
    logic [31:0] r_n3 [4][4];
    logic [31:0] r_n4 [4][4];
    logic [31:0] r_m1 [4][4];
    logic [31:0] r_m2 [4][4];
    logic signed [HW-1:0] r_h [4][4];
    logic signed [HW-1:0] r_s [2][2];
    logic signed [HW-1:0] r_top, r_bot;
    logic [16:0] r_wx [2:6];
    logic [16:0] r_wy [2:7];

    assign ix = r_sx[21:16];
    assign iy = r_sy[21:16];
    assign base = 32'(ix) + 32'(iy) * 32'd57;

    always_comb begin
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                n_key[a][b] = base + 32'((a - 1) + 57 * (b - 1));
                // last hash round; bits 30:14 give the 17-bit lattice value
                n_t[a][b]   = r_n4[a][b] * r_m2[a][b] + 32'd1376312589;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // scale coordinates into the lattice
        r_sx <= 22'(i_px * i_freq);
        r_sy <= 22'(i_py * i_freq);
        // lattice keys, blend weights
        r_wx[2] <= COS_W[r_sx[15:8]];
        r_wy[2] <= COS_W[r_sy[15:8]];
        for (int i = 3; i <= 6; i++) r_wx[i] <= r_wx[i - 1];
        for (int i = 3; i <= 7; i++) r_wy[i] <= r_wy[i - 1];
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                r_n2[a][b] <= (n_key[a][b] << 13) ^ n_key[a][b];
                r_n3[a][b] <= r_n2[a][b];
                r_n4[a][b] <= r_n3[a][b];
                r_m1[a][b] <= r_n2[a][b] * r_n2[a][b];
                r_m2[a][b] <= r_m1[a][b] * 32'd15731 + 32'd789221;
                r_h[a][b]  <= 18'sd65536 - $signed({1'b0, n_t[a][b][30:14]});
            end
        end
        // 3x3 smoothing around each of the four cell corners
        for (int u = 0; u < 2; u++) begin
            for (int v = 0; v < 2; v++) begin
                r_s[u][v] <= HW'((22'(r_h[u][v]) + 22'(r_h[u+2][v]) + 22'(r_h[u][v+2])
                             + 22'(r_h[u+2][v+2])
                             + ((22'(r_h[u][v+1]) + 22'(r_h[u+2][v+1]) + 22'(r_h[u+1][v])
                             + 22'(r_h[u+1][v+2])) <<< 1)
                             + (22'(r_h[u+1][v+1]) <<< 2)) >>> 4);
            end
        end
        r_top <= f_blend(r_s[0][0], r_s[1][0], r_wx[6]);
        r_bot <= f_blend(r_s[0][1], r_s[1][1], r_wx[6]);
        o_oct <= f_blend(r_top, r_bot, r_wy[7]);
    end

endmodule
`default_nettype wire

[rtl/core/vnmt_checker.sv]
// Port-level checker for the texel generator, bound to the top level.
// Depends on vnmt_pkg and value_noise_material_texel_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "value_noise_material_texel_defines.svh"
module vnmt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe
);
    import vnmt_pkg::*;

    // every request yields its result after the fixed latency
    `VNMT_ASSERT_DLY(a_result_follows, i_clk, i_rst_n, start && !busy, LATENCY, o_strobe, "request lost")
    // no result without a request the fixed latency before
    `VNMT_ASSERT_DLY(a_no_invented, i_clk, i_rst_n, !(start && !busy), LATENCY, !o_strobe, "result invented")
    // pipeline empty on leaving reset
    `VNMT_ASSERT_IMP(a_reset_flush, i_clk, i_rst_n, $rose(i_rst_n), !o_strobe, "stale result after reset")

endmodule

bind value_noise_material_texel vnmt_checker u_checker (.*);
`default_nettype wire
